// ----- design/pssv_pkg.sv -----
// Shared types, constants and helper functions for the plucked string voice.
// Used by the core, noise and tick modules and the testbench; depends on nothing else.
`default_nettype none

package pssv_pkg;

  localparam int DELAY_DEPTH = 4096;
  localparam int DELAY_AW    = $clog2(DELAY_DEPTH);
  localparam int MIN_DELAY   = 4;

  localparam int SR_W     = 18;
  localparam int FB_W     = 16;
  localparam int DMP_W    = 17;
  localparam int SAMPLE_W = 16;
  localparam int REMAIN_W = SR_W + 1;
  localparam int NOTE_W   = 7;

  localparam logic [SR_W-1:0]  SR_MIN    = 18'd8000;
  localparam logic [SR_W-1:0]  SR_MAX    = 18'd192000;
  localparam logic [SR_W-1:0]  SR_RESET  = 18'd44100;
  localparam logic [FB_W-1:0]  FB_MIN    = 16'd58982;
  localparam logic [FB_W-1:0]  FB_MAX    = 16'd65529;
  localparam logic [FB_W-1:0]  FB_RESET  = 16'd65405;
  localparam logic [DMP_W-1:0] DMP_MAX   = 17'd65536;
  localparam logic [DMP_W-1:0] DMP_RESET = 17'd32768;

  localparam logic [DELAY_AW-1:0] LEN_RESET = DELAY_AW'(100);

  localparam logic [31:0] SEED_NOTE_MUL = 32'd12345;
  localparam logic [31:0] SEED_VEL_MUL  = 32'd6789;
  localparam logic [17:0] RECIP_127     = 18'd132104;
  localparam logic [12:0] DIV12_MUL     = 13'd43;

  localparam logic signed [SAMPLE_W-1:0] SILENCE_LEVEL = 16'sd3;

  localparam logic KIND_PLUCK = 1'b0;
  localparam logic KIND_TICK  = 1'b1;

  typedef enum logic [1:0] {
    CFG_SAMPLE_RATE = 2'd0,
    CFG_FEEDBACK    = 2'd1,
    CFG_DAMPING     = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic              kind;
    logic [NOTE_W-1:0] note;
    logic [NOTE_W-1:0] velocity;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       voice_active;
  } out_word_t;

  typedef struct packed {
    logic [SR_W-1:0]  sample_rate;
    logic [FB_W-1:0]  feedback_q16;
    logic [DMP_W-1:0] damping_q16;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic adv;
  } noise_ctrl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_P_PER,
    ST_P_MUL,
    ST_P_LEN,
    ST_F_GEN,
    ST_F_MUL,
    ST_F_WR,
    ST_T_MUL,
    ST_T_Y,
    ST_T_FB,
    ST_T_WB
  } state_t;

  function automatic logic [31:0] xorshift32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  // Period of each semitone of the lowest octave in units of 2^-32 s.
  function automatic logic [31:0] period_q32(input logic [3:0] semi);
    logic [31:0] p;
    case (semi)
      4'd0:    p = 32'd525326924;
      4'd1:    p = 32'd495842589;
      4'd2:    p = 32'd468013083;
      4'd3:    p = 32'd441745527;
      4'd4:    p = 32'd416952256;
      4'd5:    p = 32'd393550524;
      4'd6:    p = 32'd371462230;
      4'd7:    p = 32'd350613657;
      4'd8:    p = 32'd330935225;
      4'd9:    p = 32'd312361258;
      4'd10:   p = 32'd294829768;
      4'd11:   p = 32'd278282244;
      default: p = '0;
    endcase
    return p;
  endfunction

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [35:0] v);
    logic signed [SAMPLE_W-1:0] r;
    if (v > 36'sd32767) begin
      r = 16'sh7fff;
    end else if (v < -36'sd32768) begin
      r = -16'sh8000;
    end else begin
      r = signed'(v[SAMPLE_W-1:0]);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- design/plucked_string_synth_voice_core.sv -----
// Top level of the one-voice plucked string synthesizer.
// Depends on pssv_pkg, pssv_ram, pssv_noise and pssv_tick.
//
// Input words arrive on in_valid/in_ready with a kind, a note and a velocity.
// A pluck word (kind 0) with non-zero velocity sets the delay length L from
// the note and the sample rate and fills L delay entries with scaled noise.
// It runs the period, multiply and length steps, then the generate, divide
// and write loop over the delay memory once per entry, before the next word
// is accepted. A pluck with zero velocity is accepted and leaves the core
// idle. Plucks give no output word.
// A tick word (kind 1) gives one output word on out_valid/out_ready. It passes
// through one delay memory read, then the mix multiply, rounding, the feedback
// multiply and the write-back before the next word is accepted.
// The output register holds a finished word while the next input word is
// accepted; if the receiver still stalls when a tick reaches its write-back,
// the tick waits there without touching the voice state.
// Reset is synchronous and needs no clearing pass; the voice is silent after
// it. Configuration writes on cfg_we take effect at once; the user must make
// them while the core is idle, as the block itself does not enforce this.
`default_nettype none

module plucked_string_synth_voice_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  pssv_pkg::in_word_t            in_word,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pssv_pkg::out_word_t           out_word,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [pssv_pkg::SR_W-1:0]     cfg_data
);
  import pssv_pkg::*;

  state_t                     state;
  state_t                     state_next;
  cfg_t                       cfg;
  logic [DELAY_AW-1:0]        delay_length;
  logic [DELAY_AW-1:0]        write_index;
  logic [DELAY_AW-1:0]        read_index;
  logic [DELAY_AW-1:0]        rd_index_next;
  logic [DELAY_AW-1:0]        fill_index;
  logic signed [SAMPLE_W-1:0] previous_output;
  logic                       sounding;
  logic [REMAIN_W-1:0]        samples_remaining;
  logic [REMAIN_W-1:0]        remaining_dec;
  logic                       tick_live;
  logic [NOTE_W-1:0]          pl_note;
  logic [NOTE_W-1:0]          pl_vel;
  logic [12:0]                note_x43;
  logic [3:0]                 octave;
  logic [NOTE_W-1:0]          semi_full;
  logic [31:0]                period;
  logic [49:0]                len_prod;
  logic [17:0]                len_raw;
  logic [DELAY_AW-1:0]        len_clamped;
  logic [SR_W-1:0]            sr_clamped;
  logic [31:0]                seed;
  noise_ctrl_t                noise_ctrl;
  logic signed [SAMPLE_W-1:0] noise_entry;
  logic signed [SAMPLE_W-1:0] ram_rdata;
  logic signed [SAMPLE_W-1:0] tick_y;
  logic signed [SAMPLE_W-1:0] tick_fb;
  logic                       ram_we;
  logic [DELAY_AW-1:0]        ram_waddr;
  logic signed [SAMPLE_W-1:0] ram_wdata;
  logic                       in_fire;
  logic                       out_free;
  logic                       fill_last;
  logic                       going_silent;
  logic                       tick_commit;
  logic                       pluck_done;

  pssv_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DELAY_DEPTH)
  ) u_delay (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_index_next),
    .rdata (ram_rdata)
  );

  pssv_noise u_noise (
    .clk      (clk),
    .ctrl     (noise_ctrl),
    .seed     (seed),
    .velocity (pl_vel),
    .entry    (noise_entry)
  );

  pssv_tick u_tick (
    .clk     (clk),
    .cfg     (cfg),
    .cur     (ram_rdata),
    .prev    (previous_output),
    .y       (tick_y),
    .fb_word (tick_fb)
  );

  always_comb begin
    in_fire       = in_valid & in_ready;
    out_free      = !out_valid || out_ready;
    rd_index_next = (write_index == delay_length - DELAY_AW'(1)) ? '0
                                                                 : write_index + DELAY_AW'(1);
    note_x43      = 13'(pl_note) * DIV12_MUL;
    octave        = note_x43[12:9];
    semi_full     = pl_note - NOTE_W'(octave) * NOTE_W'(12);
    if (cfg.sample_rate < SR_MIN) begin
      sr_clamped = SR_MIN;
    end else if (cfg.sample_rate > SR_MAX) begin
      sr_clamped = SR_MAX;
    end else begin
      sr_clamped = cfg.sample_rate;
    end
    len_raw = len_prod[49:32];
    if (len_raw < 18'(MIN_DELAY)) begin
      len_clamped = DELAY_AW'(MIN_DELAY);
    end else if (len_raw > 18'(DELAY_DEPTH - 1)) begin
      len_clamped = DELAY_AW'(DELAY_DEPTH - 1);
    end else begin
      len_clamped = len_raw[DELAY_AW-1:0];
    end
    seed          = 32'(pl_note) * SEED_NOTE_MUL + 32'(pl_vel) * SEED_VEL_MUL;
    fill_last     = (fill_index == delay_length - DELAY_AW'(1));
    remaining_dec = samples_remaining - REMAIN_W'(1);
    going_silent  = (remaining_dec == '0) ||
                    ((tick_y <= SILENCE_LEVEL) && (tick_y >= -SILENCE_LEVEL));
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_word.kind == KIND_TICK) begin
            state_next = ST_T_MUL;
          end else if (in_word.velocity != '0) begin
            state_next = ST_P_PER;
          end
        end
      end
      ST_P_PER: state_next = ST_P_MUL;
      ST_P_MUL: state_next = ST_P_LEN;
      ST_P_LEN: state_next = ST_F_GEN;
      ST_F_GEN: state_next = ST_F_MUL;
      ST_F_MUL: state_next = ST_F_WR;
      ST_F_WR:  state_next = fill_last ? ST_IDLE : ST_F_GEN;
      ST_T_MUL: state_next = ST_T_Y;
      ST_T_Y:   state_next = ST_T_FB;
      ST_T_FB:  state_next = ST_T_WB;
      ST_T_WB:  state_next = out_free ? ST_IDLE : ST_T_WB;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready    = 1'b0;
    noise_ctrl  = '0;
    ram_we      = 1'b0;
    ram_waddr   = fill_index;
    ram_wdata   = noise_entry;
    tick_commit = 1'b0;
    pluck_done  = 1'b0;
    case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_P_LEN: noise_ctrl.load = 1'b1;
      ST_F_GEN: noise_ctrl.adv = 1'b1;
      ST_F_WR: begin
        ram_we     = 1'b1;
        pluck_done = fill_last;
      end
      ST_T_WB: begin
        if (out_free) begin
          tick_commit = 1'b1;
          ram_we      = tick_live;
          ram_waddr   = write_index;
          ram_wdata   = tick_fb;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= ST_IDLE;
      cfg.sample_rate   <= SR_RESET;
      cfg.feedback_q16  <= FB_RESET;
      cfg.damping_q16   <= DMP_RESET;
      delay_length      <= LEN_RESET;
      write_index       <= '0;
      previous_output   <= '0;
      sounding          <= 1'b0;
      samples_remaining <= '0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_SAMPLE_RATE: cfg.sample_rate  <= cfg_data;
          CFG_FEEDBACK:    cfg.feedback_q16 <= cfg_data[FB_W-1:0];
          CFG_DAMPING:     cfg.damping_q16  <= cfg_data[DMP_W-1:0];
          default: ;
        endcase
      end
      if (state == ST_P_LEN) begin
        delay_length <= len_clamped;
      end
      if (pluck_done) begin
        write_index       <= '0;
        previous_output   <= '0;
        sounding          <= 1'b1;
        samples_remaining <= {sr_clamped, 1'b0};
      end
      if (tick_commit) begin
        if (tick_live) begin
          previous_output   <= tick_y;
          write_index       <= read_index;
          samples_remaining <= remaining_dec;
          sounding          <= !going_silent;
        end else begin
          sounding <= 1'b0;
        end
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      pl_note    <= in_word.note;
      pl_vel     <= in_word.velocity;
      tick_live  <= sounding && (samples_remaining != '0);
      read_index <= rd_index_next;
    end
    if (state == ST_P_PER) begin
      period <= period_q32(semi_full[3:0]) >> octave;
    end
    if (state == ST_P_MUL) begin
      len_prod <= 50'(sr_clamped) * 50'(period);
    end
    if (state == ST_P_LEN) begin
      fill_index <= '0;
    end else if (state == ST_F_WR) begin
      fill_index <= fill_index + DELAY_AW'(1);
    end
    if (tick_commit) begin
      if (tick_live) begin
        out_word.sample_out   <= tick_y;
        out_word.voice_active <= !going_silent;
      end else begin
        out_word.sample_out   <= '0;
        out_word.voice_active <= 1'b0;
      end
    end
  end

  a_sounding_has_count: assert property (@(posedge clk) disable iff (rst)
    sounding |-> (samples_remaining != '0))
    else $error("voice sounding with an empty sample counter");

  a_idle_index_in_line: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |->
      ((write_index < delay_length) && (delay_length >= DELAY_AW'(MIN_DELAY))))
    else $error("write position outside the delay line while idle");

  a_output_from_writeback: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_T_WB))
    else $error("output word raised outside the tick write-back");

endmodule

`default_nettype wire

// ----- design/pssv_ram.sv -----
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; holds the delay line of the voice.
`default_nettype none

module pssv_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ----- design/pssv_noise.sv -----
// Pluck noise source: xorshift32 generator and velocity scaling by v*vel/127.
// Depends on pssv_pkg.
`default_nettype none

module pssv_noise (
  input  logic                                 clk,
  input  pssv_pkg::noise_ctrl_t                ctrl,
  input  logic [31:0]                          seed,
  input  logic [pssv_pkg::NOTE_W-1:0]          velocity,
  output logic signed [pssv_pkg::SAMPLE_W-1:0] entry
);
  import pssv_pkg::*;

  logic [31:0]          rng;
  logic [31:0]          rng_next;
  logic signed [15:0]   centered;
  logic                 neg_next;
  logic [15:0]          mag_next;
  logic [22:0]          scaled_next;
  logic [22:0]          scaled;
  logic                 neg;
  logic [22:0]          scaled_d;
  logic                 neg_d;
  logic [40:0]          recip_prod;
  logic [16:0]          quot_lo;
  logic [23:0]          quot_x127;
  logic [23:0]          rem;
  logic [16:0]          quot;

  always_comb begin
    rng_next    = xorshift32(rng);
    centered    = signed'(rng_next[15:0] ^ 16'h8000);
    neg_next    = centered[15];
    mag_next    = neg_next ? (16'd0 - 16'(centered)) : 16'(centered);
    scaled_next = 23'(mag_next) * 23'(velocity);
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      rng <= seed;
    end else if (ctrl.adv) begin
      rng    <= rng_next;
      scaled <= scaled_next;
      neg    <= neg_next;
    end
    recip_prod <= 41'(scaled) * 41'(RECIP_127);
    scaled_d   <= scaled;
    neg_d      <= neg;
  end

  // The reciprocal estimate is low by at most one; one compare fixes it.
  always_comb begin
    quot_lo   = recip_prod[40:24];
    quot_x127 = (24'(quot_lo) << 7) - 24'(quot_lo);
    rem       = 24'(scaled_d) - quot_x127;
    quot      = (rem >= 24'd127) ? quot_lo + 17'd1 : quot_lo;
    entry     = neg_d ? signed'(16'(17'd0 - quot)) : signed'(quot[15:0]);
  end

endmodule

`default_nettype wire

// ----- design/pssv_tick.sv -----
// Tick datapath: damped average of the delay tap and the last output, then
// the feedback gain for the write-back. Depends on pssv_pkg.
`default_nettype none

module pssv_tick (
  input  logic                                 clk,
  input  pssv_pkg::cfg_t                       cfg,
  input  logic signed [pssv_pkg::SAMPLE_W-1:0] cur,
  input  logic signed [pssv_pkg::SAMPLE_W-1:0] prev,
  output logic signed [pssv_pkg::SAMPLE_W-1:0] y,
  output logic signed [pssv_pkg::SAMPLE_W-1:0] fb_word
);
  import pssv_pkg::*;

  logic [DMP_W-1:0]    damp;
  logic [FB_W-1:0]     fb;
  logic signed [16:0]  diff;
  logic signed [34:0]  mix_prod;
  logic signed [35:0]  mix_sum;
  logic signed [32:0]  fb_prod;
  logic signed [35:0]  fb_sum;

  always_comb begin
    damp = (cfg.damping_q16 > DMP_MAX) ? DMP_MAX : cfg.damping_q16;
    if (cfg.feedback_q16 < FB_MIN) begin
      fb = FB_MIN;
    end else if (cfg.feedback_q16 > FB_MAX) begin
      fb = FB_MAX;
    end else begin
      fb = cfg.feedback_q16;
    end
    diff    = 17'(cur) - 17'(prev);
    mix_sum = (36'(prev) <<< 16) + 36'(mix_prod) + 36'sd32768;
    fb_sum  = 36'(fb_prod) + 36'sd32768;
    fb_word = sat16(fb_sum >>> 16);
  end

  // d*cur + (1-d)*prev is formed as prev + d*(cur-prev) with one multiply.
  always_ff @(posedge clk) begin
    mix_prod <= 35'(signed'({1'b0, damp})) * 35'(diff);
    y        <= sat16(mix_sum >>> 16);
    fb_prod  <= 33'(y) * 33'(signed'({1'b0, fb}));
  end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// Self-checking testbench for the plucked string voice core.
// Predicts every output word from a behavioral model of the string kept in this file.
// Depends on pssv_pkg and plucked_string_synth_voice_core.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pssv_pkg::*;

  localparam logic [1:0] BAD_CFG_INDEX = 2'd3;
  localparam int QUIET_CYCLES = 3 * DELAY_DEPTH + 64;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int RANDOM_WORDS = 1150;
  localparam int RANDOM_PHASES = 5;
  localparam int SUSTAIN_TICKS = 240;
  localparam logic [12*32-1:0] OCTAVE0_PERIOD = {
    32'd278282244, 32'd294829768, 32'd312361258, 32'd330935225,
    32'd350613657, 32'd371462230, 32'd393550524, 32'd416952256,
    32'd441745527, 32'd468013083, 32'd495842589, 32'd525326924
  };

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_word_t in_word;
  logic out_valid;
  logic out_ready;
  out_word_t out_word;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [SR_W-1:0] cfg_data;

  int fail_count = 0;
  int words_sent = 0;
  int samples_checked = 0;
  int cycle_count = 0;
  bit steady = 0;
  out_word_t expected_samples[$];

  logic [SR_W-1:0] rate_reg = SR_RESET;
  logic [FB_W-1:0] feedback_reg = FB_RESET;
  logic [DMP_W-1:0] damping_reg = DMP_RESET;
  logic signed [SAMPLE_W-1:0] line_mem [DELAY_DEPTH];
  int line_len = int'(LEN_RESET);
  int line_pos = 0;
  logic signed [SAMPLE_W-1:0] last_sample = '0;
  bit ringing = 0;
  int ticks_left = 0;

  plucked_string_synth_voice_core DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timeout after %0d cycles with %0d words outstanding", cycle_count,
             expected_samples.size());
    $display("FAIL plucked_string_synth_voice_core");
    $finish;
  end

  function automatic logic signed [SAMPLE_W-1:0] clip_q15(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return 16'(v);
  endfunction

  function automatic void pluck_string(logic [NOTE_W-1:0] note, logic [NOTE_W-1:0] vel);
    longint unsigned rate;
    longint unsigned span;
    logic [31:0] period;
    logic [31:0] seed;
    int v;
    rate = (rate_reg < SR_MIN) ? SR_MIN : (rate_reg > SR_MAX) ? SR_MAX : rate_reg;
    period = OCTAVE0_PERIOD[32*(note % 12) +: 32] >> (note / 12);
    span = (rate * period) >> 32;
    if (span < MIN_DELAY) span = MIN_DELAY;
    if (span > DELAY_DEPTH - 1) span = DELAY_DEPTH - 1;
    line_len = int'(span);
    seed = 32'(note) * SEED_NOTE_MUL + 32'(vel) * SEED_VEL_MUL;
    for (int i = 0; i < line_len; i++) begin
      seed = seed ^ (seed << 13);
      seed = seed ^ (seed >> 17);
      seed = seed ^ (seed << 5);
      v = int'(seed[15:0]) - 32768;
      line_mem[i] = 16'((v * int'(vel)) / 127);
    end
    line_pos = 0;
    last_sample = '0;
    ringing = 1;
    ticks_left = 2 * int'(rate);
  endfunction

  function automatic out_word_t advance_string();
    out_word_t w;
    longint d;
    longint fb;
    longint acc;
    int rd;
    logic signed [SAMPLE_W-1:0] y;
    w.sample_out = '0;
    if (ringing && ticks_left != 0) begin
      d = (damping_reg > DMP_MAX) ? DMP_MAX : damping_reg;
      fb = (feedback_reg < FB_MIN) ? FB_MIN : (feedback_reg > FB_MAX) ? FB_MAX : feedback_reg;
      rd = (line_pos + 1) % line_len;
      acc = d * line_mem[rd] + (65536 - d) * last_sample;
      y = clip_q15((acc + 32768) >>> 16);
      last_sample = y;
      line_mem[line_pos] = clip_q15((longint'(y) * fb + 32768) >>> 16);
      line_pos = (line_pos + 1) % line_len;
      ticks_left--;
      if (ticks_left == 0 || (y <= SILENCE_LEVEL && y >= -SILENCE_LEVEL)) ringing = 0;
      w.sample_out = y;
    end else begin
      ringing = 0;
    end
    w.voice_active = ringing;
    return w;
  endfunction

  function automatic int pick_gap();
    int roll;
    if (steady) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  initial begin : sink_ready
    int hold;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      out_ready <= 1'b1;
      hold = $urandom_range(1, 12);
      repeat (hold) @(posedge clk);
      hold = pick_gap();
      if (hold > 0) begin
        out_ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
    end
  end

  initial begin : sample_check
    out_word_t want;
    forever begin
      @(posedge clk);
      if (rst === 1'b0 && out_valid === 1'b1 && out_ready === 1'b1) begin
        samples_checked++;
        if (expected_samples.size() == 0) begin
          $error("Unexpected output word: sample_out %0d voice_active %0b",
                 out_word.sample_out, out_word.voice_active);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_word.sample_out !== want.sample_out) begin
            $error("sample_out mismatch: expected %0d, actual %0d",
                   want.sample_out, out_word.sample_out);
            fail_count++;
          end
          if (out_word.voice_active !== want.voice_active) begin
            $error("voice_active mismatch: expected %0b, actual %0b",
                   want.voice_active, out_word.voice_active);
            fail_count++;
          end
        end
      end
    end
  end

  task automatic send_word(logic kind, logic [NOTE_W-1:0] note, logic [NOTE_W-1:0] vel);
    in_word_t w;
    int gap;
    w.kind = kind;
    w.note = note;
    w.velocity = vel;
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_ready !== 1'b1);
    words_sent++;
    if (kind == KIND_TICK) begin
      expected_samples.push_back(advance_string());
    end else if (vel != 0) begin
      pluck_string(note, vel);
    end
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_tick();
    send_word(KIND_TICK, 7'($urandom), 7'($urandom));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
  endtask

  // A pluck gives no word back, so its fill may still run after the last sample.
  task automatic settle_idle();
    drain_results();
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [SR_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    case (idx)
      CFG_SAMPLE_RATE: rate_reg = value;
      CFG_FEEDBACK: feedback_reg = value[FB_W-1:0];
      CFG_DAMPING: damping_reg = value[DMP_W-1:0];
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_idle_ticks();
    send_tick();
    send_tick();
    send_word(KIND_PLUCK, 7'd127, 7'd0);
    send_tick();
  endtask

  task automatic test_pluck_basics();
    send_word(KIND_PLUCK, 7'd69, 7'd127);
    repeat (8) send_tick();
    send_word(KIND_PLUCK, 7'd127, 7'd127);
    repeat (6) send_tick();
    send_word(KIND_PLUCK, 7'd60, 7'd0);
    send_tick();
    send_word(KIND_PLUCK, 7'd0, 7'd1);
    repeat (3) send_tick();
    send_word(KIND_PLUCK, 7'd12, 7'd64);
    repeat (2) send_tick();
  endtask

  task automatic test_register_limits();
    settle_idle();
    write_reg(CFG_SAMPLE_RATE, '0);
    write_reg(CFG_FEEDBACK, '0);
    write_reg(CFG_DAMPING, '0);
    write_reg(BAD_CFG_INDEX, '1);
    send_word(KIND_PLUCK, 7'd69, 7'd100);
    repeat (3) send_tick();
    settle_idle();
    write_reg(CFG_SAMPLE_RATE, '1);
    write_reg(CFG_FEEDBACK, 18'h0ffff);
    write_reg(CFG_DAMPING, 18'h1ffff);
    send_word(KIND_PLUCK, 7'd0, 7'd127);
    repeat (4) send_tick();
    send_word(KIND_PLUCK, 7'd127, 7'd127);
    repeat (3) send_tick();
  endtask

  // At the lowest rate the shortest string barely decays, so it keeps ringing
  // through a long run of back-to-back ticks.
  task automatic test_slow_decay();
    int guard;
    settle_idle();
    write_reg(CFG_SAMPLE_RATE, SR_MIN);
    write_reg(CFG_FEEDBACK, 18'(FB_MAX));
    write_reg(CFG_DAMPING, 18'(DMP_MAX));
    send_word(KIND_PLUCK, 7'd127, 7'd127);
    steady = 1;
    guard = 0;
    while (ringing && guard < SUSTAIN_TICKS) begin
      send_tick();
      guard++;
    end
    steady = 0;
    repeat (2) send_tick();
  endtask

  task automatic test_random_traffic();
    int counted;
    int goal;
    int drain_at;
    int burst;
    int pick;
    logic [NOTE_W-1:0] note;
    counted = 0;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle_idle();
      pick = $urandom_range(0, 9);
      write_reg(CFG_SAMPLE_RATE, pick == 0 ? 18'($urandom_range(0, 7999)) :
                pick == 1 ? 18'($urandom_range(192001, 262143)) :
                pick == 2 ? SR_MIN : pick == 3 ? SR_MAX : 18'($urandom_range(8000, 96000)));
      pick = $urandom_range(0, 9);
      write_reg(CFG_FEEDBACK, pick == 0 ? 18'($urandom_range(0, 58981)) :
                pick == 1 ? 18'($urandom_range(65530, 65535)) :
                18'($urandom_range(58982, 65529)));
      pick = $urandom_range(0, 9);
      write_reg(CFG_DAMPING, pick == 0 ? 18'($urandom_range(65537, 131071)) :
                pick == 1 ? 18'(DMP_MAX) : 18'($urandom_range(1, 65536)));
      goal = (phase + 1) * RANDOM_WORDS / RANDOM_PHASES;
      drain_at = counted + $urandom_range(10, 150);
      while (counted < goal) begin
        steady = ($urandom_range(0, 5) == 0);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          send_word(KIND_PLUCK, 7'($urandom), '0);
        end else if (pick < 16) begin
          burst = $urandom_range(1, 6);
          repeat (burst) send_tick();
          counted += burst;
        end else begin
          note = ($urandom_range(0, 9) == 0) ? 7'($urandom) : 7'($urandom_range(60, 127));
          send_word(KIND_PLUCK, note, 7'($urandom_range(1, 127)));
          burst = ($urandom_range(0, 7) == 0) ? $urandom_range(80, 200) : $urandom_range(3, 40);
          repeat (burst) send_tick();
          counted += burst + 1;
        end
        if (counted >= drain_at) begin
          drain_results();
          drain_at = goal + RANDOM_WORDS;
        end
      end
    end
    steady = 0;
  endtask

  initial begin
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_word <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_idle_ticks();
    test_pluck_basics();
    test_register_limits();
    test_slow_decay();
    test_random_traffic();
    settle_idle();
    $display("Run covered %0d input words and %0d checked sample words,", words_sent,
             samples_checked);
    $display("with clamped register extremes, retriggered plucks, silent ticks and a slow decay.");
    if (fail_count == 0) begin
      $display("PASS plucked_string_synth_voice_core");
    end else begin
      $display("FAIL plucked_string_synth_voice_core");
    end
    $finish;
  end

endmodule

`default_nettype wire
